/* design/bra_pkg.sv */
// Shared types, field widths and codes of the bitmap run allocator.
// No dependencies; compile first.
package bra_pkg;

  localparam int OP_W  = 3;
  localparam int IDX_W = 10;
  localparam int CNT_W = 11;
  localparam int LIM_W = 11;

  localparam logic [LIM_W-1:0] LIM_RESET = 11'd1024;

  localparam int DEF_MAP_BITS  = 1024;
  localparam int DEF_WORD_BITS = 32;

  localparam int APB_DW    = 32;
  localparam int REG_IDX_W = 1;
  localparam int APB_AW    = REG_IDX_W + 2;

  localparam logic [REG_IDX_W-1:0] REG_BITS_IN_USE = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_SET_BIT   = 3'd0,
    OP_CLR_BIT   = 3'd1,
    OP_TEST_BIT  = 3'd2,
    OP_SET_RANGE = 3'd3,
    OP_ALLOC_RUN = 3'd4,
    OP_ALLOC_ONE = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    MARK_SET,
    MARK_CLR,
    MARK_TEST
  } mark_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOCATE,
    ST_SCAN,
    ST_MARK_RD,
    ST_MARK_WR,
    ST_DONE
  } state_e;

endpackage

/* design/bra_in_if.sv */
// Request channel of the bitmap run allocator: valid/ready plus request fields.
// Depends on bra_pkg.
interface bra_in_if;
  import bra_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [IDX_W-1:0] bit_index;
  logic [CNT_W-1:0] run_length;

  modport source (output valid, output op, output bit_index, output run_length, input ready);
  modport sink   (input valid, input op, input bit_index, input run_length, output ready);
endinterface

/* design/bra_out_if.sv */
// Result channel of the bitmap run allocator: valid/ready plus result fields.
// Depends on bra_pkg.
interface bra_out_if;
  import bra_pkg::*;

  logic             valid;
  logic             ready;
  logic             status;
  logic [IDX_W-1:0] base_index;
  logic             bit_value;

  modport source (output valid, output status, output base_index, output bit_value, input ready);
  modport sink   (input valid, input status, input base_index, input bit_value, output ready);
endinterface

/* design/bra_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bra_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 32,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* design/bra_word_unit.sv */
// Shared word evaluator: first-fit run search, top-down free search and
// range masking over one bitmap word. Depends on bra_pkg.
module bra_word_unit #(
  parameter int W  = 32,
  parameter int CW = 11
) (
  input  logic [W-1:0]       data_i,
  input  logic [CW-1:0]      base_i,
  input  logic [CW-1:0]      lim_i,
  input  logic [CW-1:0]      cnt_i,
  input  logic [CW-1:0]      carry_i,
  input  logic [CW-1:0]      lo_i,
  input  logic [CW-1:0]      hi_i,
  input  bra_pkg::mark_e     mode_i,
  output logic               up_hit_o,
  output logic [CW-1:0]      up_pos_o,
  output logic [CW-1:0]      carry_o,
  output logic               dn_hit_o,
  output logic [CW-1:0]      dn_pos_o,
  output logic [W-1:0]       wr_data_o,
  output logic               test_bit_o
);
  import bra_pkg::*;

  localparam int BW = (W > 1) ? $clog2(W) : 1;

  function automatic logic [BW-1:0] lsb_pos(input logic [W-1:0] v);
    logic [BW-1:0] p;
    p = '0;
    for (int i = W - 1; i >= 0; i--) begin
      if (v[i]) p = BW'(i);
    end
    return p;
  endfunction

  function automatic logic [BW-1:0] msb_pos(input logic [W-1:0] v);
    logic [BW-1:0] p;
    p = '0;
    for (int i = 0; i < W; i++) begin
      if (v[i]) p = BW'(i);
    end
    return p;
  endfunction

  logic [CW-1:0] pos [W];
  logic [W-1:0]  used;
  logic [W-1:0]  hit;
  logic [W-1:0]  mask;

  always_comb begin
    for (int b = 0; b < W; b++) begin
      pos[b]  = base_i + CW'(b);
      used[b] = data_i[b] | (pos[b] >= lim_i);
      mask[b] = (pos[b] >= lo_i) && (pos[b] <= hi_i);
    end
  end

  // hit at b: the free run ending at b holds at least cnt bits
  always_comb begin
    logic [W-1:0] win;
    logic [W-1:0] low;
    for (int b = 0; b < W; b++) begin
      for (int j = 0; j < W; j++) begin
        low[j] = (j <= b);
        win[j] = (j <= b) && (cnt_i >= CW'(b - j + 1));
      end
      if (cnt_i <= CW'(b + 1)) begin
        hit[b] = ((used & win) == '0);
      end else begin
        hit[b] = ((used & low) == '0) &&
                 ((CW+1)'(carry_i) + (CW+1)'(b + 1) >= (CW+1)'(cnt_i));
      end
    end
  end

  always_comb begin
    up_hit_o = |hit;
    up_pos_o = base_i + CW'(lsb_pos(hit));
    if (used == '0) begin
      carry_o = carry_i + CW'(W);
    end else begin
      carry_o = CW'(W - 1) - CW'(msb_pos(used));
    end
    dn_hit_o   = |(~used);
    dn_pos_o   = base_i + CW'(msb_pos(~used));
    test_bit_o = |(data_i & mask);
    case (mode_i)
      MARK_SET: wr_data_o = data_i | mask;
      MARK_CLR: wr_data_o = data_i & ~mask;
      default:  wr_data_o = data_i;
    endcase
  end

endmodule

/* design/bitmap_run_allocator_core.sv */
// Bitmap run allocator top level: request sequencer, APB register, map RAM.
// Depends on bra_pkg, bra_in_if, bra_out_if, bra_ram and bra_word_unit.
//
// One request at a time, one result beat per request. After reset the map RAM
// is cleared one word per cycle, all MAP_WORDS words (32 by default), before
// the first request is taken. Via the single word evaluator and registered-read
// map RAM, set and clear bit locate, read and write one word and test bit only
// reads it; set range locates, reads and writes each word touched; allocate
// run scans up word by word to the first fit, locates again, then reads and
// writes each word of the run; allocate one scans down from the limit the same
// way and then writes one word. Requests that fail their checks go straight to
// done. The result register lets the result wait while the block goes idle.
module bitmap_run_allocator_core #(
  parameter int MAP_BITS  = bra_pkg::DEF_MAP_BITS,
  parameter int WORD_BITS = bra_pkg::DEF_WORD_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  bra_in_if.sink                      req_i,
  bra_out_if.source                   rsp_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bra_pkg::APB_AW-1:0]  paddr,
  input  logic [bra_pkg::APB_DW-1:0]  pwdata,
  output logic [bra_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import bra_pkg::*;

  localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int IW        = $clog2(MAP_BITS) + 1;
  localparam int CW        = (IW > CNT_W) ? IW : CNT_W;
  localparam int LW        = $clog2(WORD_BITS);
  localparam int SH        = CW + LW;
  localparam int RECIP     = ((2 ** SH) + WORD_BITS - 1) / WORD_BITS;
  localparam int PW        = 2 * CW + 1;

  localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);

  state_e state_q, state_d;

  logic [LIM_W-1:0] biu_q;
  logic [CW-1:0]    lim;

  logic [AW-1:0] wrd_q, wrd_d;
  logic [CW-1:0] base_q, base_d;
  logic [CW-1:0] rng_lo_q, rng_lo_d;
  logic [CW-1:0] rng_hi_q, rng_hi_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] carry_q, carry_d;
  logic          scan_q, scan_d;
  logic          dn_q, dn_d;
  logic          dvld_q, dvld_d;
  mark_e         mode_q, mode_d;

  logic             res_status_q, res_status_d;
  logic [IDX_W-1:0] res_base_q, res_base_d;
  logic             res_bit_q, res_bit_d;

  logic             out_vld_q, out_vld_d;
  logic             out_status_q, out_status_d;
  logic [IDX_W-1:0] out_base_q, out_base_d;
  logic             out_bit_q, out_bit_d;

  logic                 ram_we;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] ram_rdata;

  logic                 up_hit, dn_hit, test_bit;
  logic [CW-1:0]        up_pos, dn_pos, unit_carry;
  logic [WORD_BITS-1:0] unit_wdata;

  logic [PW-1:0] loc_prod;
  logic [AW-1:0] loc_wrd;
  logic [CW-1:0] wrd_base;

  logic          accept, out_free;
  logic          scan_hit, scan_end, mark_last;
  logic          cfg_wr;

  op_e           req_op;
  logic [CW-1:0] req_idx, req_cnt;
  logic [CW:0]   req_sum;
  logic [CW-1:0] req_end;
  logic          req_ok;
  logic [CW-1:0] req_lo, req_hi;
  logic          req_scan, req_dn;
  mark_e         req_mode;

  // configuration register
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[APB_AW-1:2] == REG_BITS_IN_USE);
  assign pready = 1'b1;
  assign prdata = (paddr[APB_AW-1:2] == REG_BITS_IN_USE) ? APB_DW'(biu_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      biu_q <= LIM_RESET;
    end else if (cfg_wr) begin
      biu_q <= pwdata[LIM_W-1:0];
    end
  end

  assign lim = (CW'(biu_q) > CW'(MAP_BITS)) ? CW'(MAP_BITS) : CW'(biu_q);

  // word index of rng_lo by reciprocal multiply
  assign loc_prod = PW'(rng_lo_q) * PW'(RECIP);
  assign loc_wrd  = AW'(loc_prod >> SH);
  assign wrd_base = CW'(wrd_q) * CW'(WORD_BITS);

  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !out_vld_q || rsp_o.ready;

  assign scan_hit  = dn_q ? dn_hit : up_hit;
  assign scan_end  = dn_q ? (base_q == '0)
                          : ((CW+1)'(base_q) + (CW+1)'(WORD_BITS) >= (CW+1)'(lim));
  assign mark_last = (CW+1)'(rng_hi_q) < (CW+1)'(base_q) + (CW+1)'(WORD_BITS);

  // request decode
  always_comb begin
    req_op   = op_e'(req_i.op);
    req_idx  = CW'(req_i.bit_index);
    req_cnt  = CW'(req_i.run_length);
    req_sum  = (CW+1)'(req_idx) + (CW+1)'(req_cnt);
    req_end  = (req_sum > (CW+1)'(lim)) ? lim : req_sum[CW-1:0];
    req_ok   = 1'b0;
    req_lo   = req_idx;
    req_hi   = req_idx;
    req_scan = 1'b0;
    req_dn   = 1'b0;
    req_mode = MARK_SET;
    case (req_op)
      OP_SET_BIT: begin
        req_ok = req_idx < lim;
      end
      OP_CLR_BIT: begin
        req_ok   = req_idx < lim;
        req_mode = MARK_CLR;
      end
      OP_TEST_BIT: begin
        req_ok   = req_idx < lim;
        req_mode = MARK_TEST;
      end
      OP_SET_RANGE: begin
        req_ok = (req_idx < lim) && (req_cnt != '0);
        req_hi = req_end - CW'(1);
      end
      OP_ALLOC_RUN: begin
        req_ok   = (req_cnt != '0) && (req_cnt <= lim);
        req_lo   = '0;
        req_scan = 1'b1;
      end
      OP_ALLOC_ONE: begin
        req_ok   = lim != '0;
        req_lo   = lim - CW'(1);
        req_scan = 1'b1;
        req_dn   = 1'b1;
      end
      default: begin
        req_ok = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (wrd_q == LAST_WORD) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_d = req_ok ? ST_LOCATE : ST_DONE;
      end
      ST_LOCATE: begin
        state_d = scan_q ? ST_SCAN : ST_MARK_RD;
      end
      ST_SCAN: begin
        if (dvld_q) begin
          if (scan_hit) begin
            state_d = ST_LOCATE;
          end else if (scan_end) begin
            state_d = ST_DONE;
          end
        end
      end
      ST_MARK_RD: begin
        state_d = ST_MARK_WR;
      end
      ST_MARK_WR: begin
        state_d = mark_last ? ST_DONE : ST_MARK_RD;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    req_i.ready      = (state_q == ST_IDLE);
    ram_we           = (state_q == ST_CLEAR) ||
                       ((state_q == ST_MARK_WR) && (mode_q != MARK_TEST));
    ram_wdata        = (state_q == ST_CLEAR) ? '0 : unit_wdata;
    rsp_o.valid      = out_vld_q;
    rsp_o.status     = out_status_q;
    rsp_o.base_index = out_base_q;
    rsp_o.bit_value  = out_bit_q;
  end

  // datapath
  always_comb begin
    wrd_d        = wrd_q;
    base_d       = base_q;
    rng_lo_d     = rng_lo_q;
    rng_hi_d     = rng_hi_q;
    cnt_d        = cnt_q;
    carry_d      = carry_q;
    scan_d       = scan_q;
    dn_d         = dn_q;
    dvld_d       = dvld_q;
    mode_d       = mode_q;
    res_status_d = res_status_q;
    res_base_d   = res_base_q;
    res_bit_d    = res_bit_q;
    out_vld_d    = out_vld_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_base_d   = out_base_q;
    out_bit_d    = out_bit_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (wrd_q != LAST_WORD) wrd_d = wrd_q + AW'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          rng_lo_d     = req_lo;
          rng_hi_d     = req_hi;
          cnt_d        = req_cnt;
          carry_d      = '0;
          scan_d       = req_scan;
          dn_d         = req_dn;
          mode_d       = req_mode;
          dvld_d       = 1'b0;
          res_status_d = !req_ok;
          res_base_d   = '0;
          res_bit_d    = 1'b0;
        end
      end
      ST_LOCATE: begin
        wrd_d  = loc_wrd;
        dvld_d = 1'b0;
      end
      ST_SCAN: begin
        dvld_d = 1'b1;
        if (dn_q) begin
          wrd_d = (wrd_q == '0) ? '0 : wrd_q - AW'(1);
        end else begin
          wrd_d = (wrd_q == LAST_WORD) ? LAST_WORD : wrd_q + AW'(1);
        end
        if (!dvld_q) begin
          base_d = wrd_base;
        end else begin
          base_d  = dn_q ? base_q - CW'(WORD_BITS) : base_q + CW'(WORD_BITS);
          carry_d = unit_carry;
          if (scan_hit) begin
            scan_d = 1'b0;
            mode_d = MARK_SET;
            if (dn_q) begin
              rng_lo_d   = dn_pos;
              rng_hi_d   = dn_pos;
              res_base_d = dn_pos[IDX_W-1:0];
            end else begin
              rng_lo_d   = up_pos + CW'(1) - cnt_q;
              rng_hi_d   = up_pos;
              res_base_d = rng_lo_d[IDX_W-1:0];
            end
          end else if (scan_end) begin
            res_status_d = 1'b1;
          end
        end
      end
      ST_MARK_RD: begin
        base_d = wrd_base;
      end
      ST_MARK_WR: begin
        if (mode_q == MARK_TEST) res_bit_d = test_bit;
        if (!mark_last) wrd_d = wrd_q + AW'(1);
      end
      ST_DONE: begin
        if (out_free) begin
          out_vld_d    = 1'b1;
          out_status_d = res_status_q;
          out_base_d   = res_base_q;
          out_bit_d    = res_bit_q;
        end
      end
      default: begin
        dvld_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      wrd_q     <= '0;
      scan_q    <= 1'b0;
      dn_q      <= 1'b0;
      dvld_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wrd_q     <= wrd_d;
      scan_q    <= scan_d;
      dn_q      <= dn_d;
      dvld_q    <= dvld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q       <= base_d;
    rng_lo_q     <= rng_lo_d;
    rng_hi_q     <= rng_hi_d;
    cnt_q        <= cnt_d;
    carry_q      <= carry_d;
    mode_q       <= mode_d;
    res_status_q <= res_status_d;
    res_base_q   <= res_base_d;
    res_bit_q    <= res_bit_d;
    out_status_q <= out_status_d;
    out_base_q   <= out_base_d;
    out_bit_q    <= out_bit_d;
  end

  bra_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wrd_q),
    .wdata_i (ram_wdata),
    .raddr_i (wrd_q),
    .rdata_o (ram_rdata)
  );

  bra_word_unit #(
    .W  (WORD_BITS),
    .CW (CW)
  ) u_word_unit (
    .data_i     (ram_rdata),
    .base_i     (base_q),
    .lim_i      (lim),
    .cnt_i      (cnt_q),
    .carry_i    (carry_q),
    .lo_i       (rng_lo_q),
    .hi_i       (rng_hi_q),
    .mode_i     (mode_q),
    .up_hit_o   (up_hit),
    .up_pos_o   (up_pos),
    .carry_o    (unit_carry),
    .dn_hit_o   (dn_hit),
    .dn_pos_o   (dn_pos),
    .wr_data_o  (unit_wdata),
    .test_bit_o (test_bit)
  );

endmodule
